// ----- rtl/dogc_pkg.sv -----
// ----------------------------------------------------------------------------
// Detector offset/gain correction package
// Shared types, codes and constants of the pixel correction pipeline.
// ----------------------------------------------------------------------------
package dogc_pkg;

	localparam int MAX_LINE_WIDTH_DEF = 4096;
	localparam int MAX_LINES_DEF      = 16;

	localparam int GAIN_FRAC_BITS = 12;
	localparam int GAIN_W         = 17;
	localparam int PIX_W          = 16;
	localparam int VALUE_W        = 17;
	localparam int X_W            = VALUE_W + 1;
	localparam int TB_W           = PIX_W + 1;
	localparam int PROD_W         = X_W + GAIN_W + 1;
	localparam int TB_SH_W        = TB_W + GAIN_FRAC_BITS;
	localparam int ACC_W          = ((PROD_W > TB_SH_W) ? PROD_W : TB_SH_W) + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [4:0] DEPTH_MIN = 5'd8;
	localparam logic [4:0] DEPTH_MAX = 5'd16;

	localparam logic             RST_OFFSET_EN       = 1'b1;
	localparam logic             RST_GAIN_EN         = 1'b1;
	localparam logic             RST_BASE_EN         = 1'b0;
	localparam logic [15:0]      RST_TARGET_BASELINE = 16'd0;
	localparam logic [4:0]       RST_OUT_DEPTH       = 5'd14;
	localparam logic [12:0]      RST_LINE_WIDTH      = 13'd4096;
	localparam logic [4:0]       RST_LINE_COUNT      = 5'd1;
	localparam logic [GAIN_W-1:0] GAIN_ONE           = GAIN_W'(1) << GAIN_FRAC_BITS;

	typedef enum logic [1:0] {
		OP_CORRECT     = 2'd0,
		OP_WR_OFFSET   = 2'd1,
		OP_WR_GAIN     = 2'd2,
		OP_WR_BASELINE = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_EN       = 3'd0,
		CFG_GAIN_EN         = 3'd1,
		CFG_BASE_EN         = 3'd2,
		CFG_TARGET_BASELINE = 3'd3,
		CFG_OUT_DEPTH       = 3'd4,
		CFG_LINE_WIDTH      = 3'd5,
		CFG_LINE_COUNT      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		opcode_t      opcode;
		logic [11:0]  column;
		logic [3:0]   row;
		logic [16:0]  value;
	} in_item_t;

	typedef struct packed {
		logic [15:0]  pixel_out;
		logic         status;
	} out_item_t;

	typedef struct packed {
		logic         offset_en;
		logic         gain_en;
		logic         base_en;
		logic [15:0]  target_baseline;
		logic [4:0]   out_depth;
		logic [12:0]  line_width;
		logic [4:0]   line_count;
	} cfg_t;

	typedef struct packed {
		opcode_t              opcode;
		logic                 err;
		logic [VALUE_W-1:0]   value;
	} mem_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   offset;
		logic [GAIN_W-1:0]  gain;
		logic [PIX_W-1:0]   baseline;
	} tbl_data_t;

endpackage

// ----- rtl/detector_offset_gain_correction_unit.sv -----
// ----------------------------------------------------------------------------
// Detector offset/gain correction unit
// Per-pixel flat-field correction with offset, gain and baseline tables.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while in_stall is low and returns one
// result per item through six register stages: an input stage that checks
// the column and maps the row, a table read stage, then offset subtract, gain
// multiply, baseline sum, and clamp with rounding into the output register.
// A stalled output backs up the pipeline stage by stage, so empty stages
// still fill. After reset the unit steps through every table entry (MAX_LINES
// capped at 16, times MAX_LINE_WIDTH) loading the reset values into the three
// tables, and holds in_stall high during that time; configuration writes are
// taken throughout.
module detector_offset_gain_correction_unit #(
	parameter int MAX_LINE_WIDTH = dogc_pkg::MAX_LINE_WIDTH_DEF,
	parameter int MAX_LINES      = dogc_pkg::MAX_LINES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [dogc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dogc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  dogc_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output dogc_pkg::out_item_t                 out_data
);

	localparam int ROWS   = (MAX_LINES < 16) ? MAX_LINES : 16;
	localparam int DEPTH  = ROWS * MAX_LINE_WIDTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dogc_pkg::cfg_t      cfg;
	dogc_pkg::mem_item_t item_s1, item_s2, item_c;
	dogc_pkg::tbl_data_t rd_s2;
	logic                valid_s1, valid_s2;
	logic                ready_s1, ready_s2;
	logic                take_s1;
	logic                clear_busy;
	logic [ADDR_W-1:0]   addr_s1, addr_c;
	logic [3:0]          row_map;
	logic                col_err;

	dogc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign col_err = ({1'b0, in_data.column} >= cfg.line_width) ||
		(32'(in_data.column) >= 32'(MAX_LINE_WIDTH));
	assign row_map = ((5'(in_data.row) >= cfg.line_count) ||
		(32'(in_data.row) >= 32'(MAX_LINES))) ? 4'd0 : in_data.row;
	assign addr_c = ADDR_W'(32'(row_map) * 32'(MAX_LINE_WIDTH) + 32'(in_data.column));

	assign item_c.opcode = in_data.opcode;
	assign item_c.err    = col_err;
	assign item_c.value  = in_data.value;

	assign take_s1  = !valid_s1 || ready_s1;
	assign in_stall = clear_busy || !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= in_valid && !clear_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1 <= item_c;
			addr_s1 <= addr_c;
		end
	end

	dogc_tables #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.addr_s1    (addr_s1),
		.ready_s1   (ready_s1),
		.valid_s2   (valid_s2),
		.item_s2    (item_s2),
		.rd_s2      (rd_s2),
		.ready_next (ready_s2),
		.clear_busy (clear_busy)
	);

	dogc_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.item_s2   (item_s2),
		.rd_s2     (rd_s2),
		.ready_s2  (ready_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// No item may be in the input or table read stage while the tables are being cleared.
	a_clear_empty_s1: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !valid_s1 && !valid_s2)
		else $error("item in table stages during clearing pass");

	a_clear_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !out_valid)
		else $error("result presented during clearing pass");

	a_err_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.pixel_out == '0)
		else $error("rejected item carries a nonzero pixel");

endmodule

// ----- rtl/dogc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the correction settings written through the plain write port.
// ----------------------------------------------------------------------------
module dogc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [dogc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dogc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output dogc_pkg::cfg_t                      cfg
);

	dogc_pkg::cfg_t cfg_q;
	logic [4:0]     depth_w;

	assign depth_w = cfg_data[4:0];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_en       <= dogc_pkg::RST_OFFSET_EN;
			cfg_q.gain_en         <= dogc_pkg::RST_GAIN_EN;
			cfg_q.base_en         <= dogc_pkg::RST_BASE_EN;
			cfg_q.target_baseline <= dogc_pkg::RST_TARGET_BASELINE;
			cfg_q.out_depth       <= dogc_pkg::RST_OUT_DEPTH;
			cfg_q.line_width      <= dogc_pkg::RST_LINE_WIDTH;
			cfg_q.line_count      <= dogc_pkg::RST_LINE_COUNT;
		end else if (cfg_write) begin
			unique case (dogc_pkg::cfg_reg_t'(cfg_index))
				dogc_pkg::CFG_OFFSET_EN: begin
					cfg_q.offset_en <= cfg_data[0];
				end
				dogc_pkg::CFG_GAIN_EN: begin
					cfg_q.gain_en <= cfg_data[0];
				end
				dogc_pkg::CFG_BASE_EN: begin
					cfg_q.base_en <= cfg_data[0];
				end
				dogc_pkg::CFG_TARGET_BASELINE: begin
					cfg_q.target_baseline <= cfg_data[15:0];
				end
				dogc_pkg::CFG_OUT_DEPTH: begin
					// Depths outside the supported range leave the register unchanged.
					if (depth_w >= dogc_pkg::DEPTH_MIN &&
						depth_w <= dogc_pkg::DEPTH_MAX) begin
						cfg_q.out_depth <= depth_w;
					end
				end
				dogc_pkg::CFG_LINE_WIDTH: begin
					cfg_q.line_width <= cfg_data[12:0];
				end
				dogc_pkg::CFG_LINE_COUNT: begin
					cfg_q.line_count <= cfg_data[4:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/dogc_tables.sv -----
// ----------------------------------------------------------------------------
// Per-pixel calibration tables
// Offset, gain and baseline memories with registered read and a clearing
// pass after reset that loads every entry with its reset value.
// ----------------------------------------------------------------------------
module dogc_tables #(
	parameter int DEPTH  = dogc_pkg::MAX_LINE_WIDTH_DEF * dogc_pkg::MAX_LINES_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	input  dogc_pkg::mem_item_t     item_s1,
	input  logic [ADDR_W-1:0]       addr_s1,
	output logic                    ready_s1,
	output logic                    valid_s2,
	output dogc_pkg::mem_item_t     item_s2,
	output dogc_pkg::tbl_data_t     rd_s2,
	input  logic                    ready_next,
	output logic                    clear_busy
);

	logic [dogc_pkg::PIX_W-1:0]  off_mem  [DEPTH];
	logic [dogc_pkg::GAIN_W-1:0] gain_mem [DEPTH];
	logic [dogc_pkg::PIX_W-1:0]  base_mem [DEPTH];

	logic              clear_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              load;
	logic              item_ok;
	logic              wr_off;
	logic              wr_gain;
	logic              wr_base;

	assign clear_busy = clear_q;
	assign ready_s1   = !valid_s2 || ready_next;
	assign load       = valid_s1 && ready_s1;
	assign item_ok    = load && !item_s1.err;
	assign wr_off     = item_ok && (item_s1.opcode == dogc_pkg::OP_WR_OFFSET);
	assign wr_gain    = item_ok && (item_s1.opcode == dogc_pkg::OP_WR_GAIN);
	assign wr_base    = item_ok && (item_s1.opcode == dogc_pkg::OP_WR_BASELINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= item_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear_q) begin
			off_mem[clr_addr_q] <= '0;
		end else if (wr_off) begin
			off_mem[addr_s1] <= item_s1.value[dogc_pkg::PIX_W-1:0];
		end
		if (load) begin
			rd_s2.offset <= off_mem[addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (clear_q) begin
			gain_mem[clr_addr_q] <= dogc_pkg::GAIN_ONE;
		end else if (wr_gain) begin
			gain_mem[addr_s1] <= item_s1.value;
		end
		if (load) begin
			rd_s2.gain <= gain_mem[addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (clear_q) begin
			base_mem[clr_addr_q] <= '0;
		end else if (wr_base) begin
			base_mem[addr_s1] <= item_s1.value[dogc_pkg::PIX_W-1:0];
		end
		if (load) begin
			rd_s2.baseline <= base_mem[addr_s1];
		end
	end

endmodule

// ----- rtl/dogc_arith.sv -----
// ----------------------------------------------------------------------------
// Correction arithmetic pipeline
// Offset subtract, gain multiply, baseline add, then clamp and round into
// the output register.
// ----------------------------------------------------------------------------
module dogc_arith (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dogc_pkg::cfg_t          cfg,
	input  logic                    valid_s2,
	input  dogc_pkg::mem_item_t     item_s2,
	input  dogc_pkg::tbl_data_t     rd_s2,
	output logic                    ready_s2,
	output logic                    out_valid,
	input  logic                    out_stall,
	output dogc_pkg::out_item_t     out_data
);

	localparam int F = dogc_pkg::GAIN_FRAC_BITS;

	logic                                  valid_s3, valid_s4, valid_s5;
	logic                                  ready_s3, ready_s4, ready_s5, ready_out;
	logic                                  corr_s3, corr_s4, corr_s5;
	logic                                  err_s3, err_s4, err_s5;
	logic signed [dogc_pkg::X_W-1:0]       x_s3;
	logic signed [dogc_pkg::TB_W-1:0]      tb_s3, tb_s4;
	logic [dogc_pkg::GAIN_W-1:0]           gain_s3;
	logic signed [dogc_pkg::PROD_W-1:0]    prod_s4;
	logic signed [dogc_pkg::ACC_W-1:0]     acc_s5;
	dogc_pkg::out_item_t                   out_q;

	logic [dogc_pkg::PIX_W-1:0]            off_eff, base_eff, maxv_c;
	logic signed [dogc_pkg::X_W-1:0]       x_c;
	logic signed [dogc_pkg::TB_W-1:0]      tb_c;
	logic signed [dogc_pkg::ACC_W-1:0]     acc_c, ceil_c, half_c, sum_c;
	logic [dogc_pkg::PIX_W-1:0]            pix_c;

	assign ready_out = !out_valid || !out_stall;
	assign ready_s5  = !valid_s5 || ready_out;
	assign ready_s4  = !valid_s4 || ready_s5;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = ready_s3;
	assign out_data  = out_q;

	assign off_eff  = cfg.offset_en ? rd_s2.offset : '0;
	assign base_eff = cfg.base_en ? rd_s2.baseline : '0;
	assign x_c  = $signed({1'b0, item_s2.value}) - $signed({2'b00, off_eff});
	assign tb_c = $signed({1'b0, cfg.target_baseline}) - $signed({1'b0, base_eff});

	assign acc_c = dogc_pkg::ACC_W'(prod_s4) + (dogc_pkg::ACC_W'(tb_s4) <<< F);

	assign maxv_c = dogc_pkg::PIX_W'((17'd1 << cfg.out_depth) - 17'd1);
	assign ceil_c = $signed(dogc_pkg::ACC_W'(maxv_c) << F);
	assign half_c = $signed(dogc_pkg::ACC_W'(1) << (F - 1));
	assign sum_c  = acc_s5 + half_c;

	always_comb begin
		if (acc_s5 < 0) begin
			pix_c = '0;
		end else if (acc_s5 > ceil_c) begin
			pix_c = maxv_c;
		end else begin
			pix_c = sum_c[F +: dogc_pkg::PIX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
			if (ready_out) begin
				out_valid <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			corr_s3 <= !item_s2.err && (item_s2.opcode == dogc_pkg::OP_CORRECT);
			err_s3  <= item_s2.err;
			x_s3    <= x_c;
			tb_s3   <= tb_c;
			gain_s3 <= cfg.gain_en ? rd_s2.gain : dogc_pkg::GAIN_ONE;
		end
		if (ready_s4) begin
			corr_s4 <= corr_s3;
			err_s4  <= err_s3;
			tb_s4   <= tb_s3;
			prod_s4 <= x_s3 * $signed({1'b0, gain_s3});
		end
		if (ready_s5) begin
			corr_s5 <= corr_s4;
			err_s5  <= err_s4;
			acc_s5  <= acc_c;
		end
		if (ready_out) begin
			out_q.pixel_out <= corr_s5 ? pix_c : '0;
			out_q.status    <= err_s5;
		end
	end

endmodule

// ----- verif/dogc_checker.sv -----
// ----------------------------------------------------------------------------
// Detector offset/gain correction checker
// Watches the configuration port and both pixel channels. It keeps its own
// copy of the three per-pixel tables and of the settings, and works out the
// corrected pixel for every input transfer. Each output transfer is then
// compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dogc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [dogc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dogc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  dogc_pkg::in_item_t               in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  dogc_pkg::out_item_t              out_data,
	output int                               errors,
	output int                               pending,
	output int                               checked
);

	localparam int     LINE_SLOTS  = dogc_pkg::MAX_LINE_WIDTH_DEF;
	localparam int     LINE_TOTAL  = dogc_pkg::MAX_LINES_DEF;
	localparam int     TABLE_SIZE  = LINE_SLOTS * LINE_TOTAL;
	localparam longint GAIN_UNIT   = longint'(1) << dogc_pkg::GAIN_FRAC_BITS;
	localparam int     PRINT_LIMIT = 100;

	logic [dogc_pkg::PIX_W-1:0]  offset_tab   [TABLE_SIZE];
	logic [dogc_pkg::GAIN_W-1:0] gain_tab     [TABLE_SIZE];
	logic [dogc_pkg::PIX_W-1:0]  baseline_tab [TABLE_SIZE];
	dogc_pkg::cfg_t              settings;
	dogc_pkg::out_item_t         corrected_q [$];
	dogc_pkg::out_item_t         oldest_pixel;

	task automatic report(input string msg);
		if (errors < PRINT_LIMIT) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		errors++;
	endtask

	task automatic update_setting(input logic [dogc_pkg::CFG_IDX_W-1:0] idx,
			input logic [dogc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			dogc_pkg::CFG_OFFSET_EN:       settings.offset_en       = data[0];
			dogc_pkg::CFG_GAIN_EN:         settings.gain_en         = data[0];
			dogc_pkg::CFG_BASE_EN:         settings.base_en         = data[0];
			dogc_pkg::CFG_TARGET_BASELINE: settings.target_baseline = data;
			dogc_pkg::CFG_OUT_DEPTH: begin
				if (data[4:0] >= dogc_pkg::DEPTH_MIN && data[4:0] <= dogc_pkg::DEPTH_MAX) begin
					settings.out_depth = data[4:0];
				end
			end
			dogc_pkg::CFG_LINE_WIDTH:      settings.line_width      = data[12:0];
			dogc_pkg::CFG_LINE_COUNT:      settings.line_count      = data[4:0];
			default: ;
		endcase
	endtask

	// Applies one input item to the tables and returns the result it causes.
	function automatic dogc_pkg::out_item_t flat_field_step(input dogc_pkg::in_item_t it);
		dogc_pkg::out_item_t res;
		logic [3:0] line;
		int         slot;
		longint     x;
		longint     acc;
		longint     ceil_scaled;
		res = '0;
		if ({1'b0, it.column} >= settings.line_width || int'(it.column) >= LINE_SLOTS) begin
			res.status = 1'b1;
			return res;
		end
		line = it.row;
		if ({1'b0, line} >= settings.line_count || int'(line) >= LINE_TOTAL) begin
			line = '0;
		end
		slot = int'(line) * LINE_SLOTS + int'(it.column);
		case (it.opcode)
			dogc_pkg::OP_WR_OFFSET:   offset_tab[slot]   = it.value[dogc_pkg::PIX_W-1:0];
			dogc_pkg::OP_WR_GAIN:     gain_tab[slot]     = it.value;
			dogc_pkg::OP_WR_BASELINE: baseline_tab[slot] = it.value[dogc_pkg::PIX_W-1:0];
			dogc_pkg::OP_CORRECT: begin
				x = longint'(it.value);
				if (settings.offset_en) begin
					x = x - longint'(offset_tab[slot]);
				end
				if (settings.gain_en) begin
					acc = x * longint'(gain_tab[slot]);
				end else begin
					acc = x * GAIN_UNIT;
				end
				if (settings.base_en) begin
					acc = acc - longint'(baseline_tab[slot]) * GAIN_UNIT;
				end
				acc = acc + longint'(settings.target_baseline) * GAIN_UNIT;
				ceil_scaled = ((longint'(1) << settings.out_depth) - 1) * GAIN_UNIT;
				if (acc < 0) begin
					acc = 0;
				end else if (acc > ceil_scaled) begin
					acc = ceil_scaled;
				end
				res.pixel_out = 16'((acc + (GAIN_UNIT >>> 1)) >>> dogc_pkg::GAIN_FRAC_BITS);
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				offset_tab[i]   = '0;
				gain_tab[i]     = dogc_pkg::GAIN_ONE;
				baseline_tab[i] = '0;
			end
			settings.offset_en       = dogc_pkg::RST_OFFSET_EN;
			settings.gain_en         = dogc_pkg::RST_GAIN_EN;
			settings.base_en         = dogc_pkg::RST_BASE_EN;
			settings.target_baseline = dogc_pkg::RST_TARGET_BASELINE;
			settings.out_depth       = dogc_pkg::RST_OUT_DEPTH;
			settings.line_width      = dogc_pkg::RST_LINE_WIDTH;
			settings.line_count      = dogc_pkg::RST_LINE_COUNT;
			corrected_q.delete();
			errors  = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (corrected_q.size() == 0) begin
					report($sformatf("result with nothing pending: pixel_out %0d status %0d",
						out_data.pixel_out, out_data.status));
				end else begin
					oldest_pixel = corrected_q.pop_front();
					if (out_data.pixel_out !== oldest_pixel.pixel_out) begin
						report($sformatf("pixel_out %0d, expected %0d (result %0d)",
							out_data.pixel_out, oldest_pixel.pixel_out, checked));
					end
					if (out_data.status !== oldest_pixel.status) begin
						report($sformatf("status %0d, expected %0d (result %0d)",
							out_data.status, oldest_pixel.status, checked));
					end
				end
			end
			if (cfg_write) begin
				update_setting(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				corrected_q.push_back(flat_field_step(in_data));
			end
			pending <= corrected_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Detector offset/gain correction testbench
// Drives table writes and pixel corrections into the unit under a series of
// register settings, with random gaps on the input and random stalls on the
// output. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int LATENCY       = 6;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 60;
	localparam logic [dogc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_write = 1'b0;
	logic [dogc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dogc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	dogc_pkg::in_item_t              in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	dogc_pkg::out_item_t             out_data;

	int          mismatch_count;
	int          results_pending;
	int          results_checked;
	int          items_sent = 0;
	int          settings_used = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          in_steady = 1'b0;
	bit          out_steady = 1'b0;
	logic [12:0] cur_width = dogc_pkg::RST_LINE_WIDTH;
	logic [4:0]  cur_lines = dogc_pkg::RST_LINE_COUNT;
	logic [11:0] hot_col [4];
	logic [3:0]  hot_row [4];

	detector_offset_gain_correction_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	dogc_checker pixel_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.errors    (mismatch_count),
		.pending   (results_pending),
		.checked   (results_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending.",
				cycle_count, results_pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int idle_len(input bit steady);
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (out_steady) begin
			out_stall <= 1'b0;
			stall_left <= $urandom_range(5, 30);
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_left <= idle_len(1'b0);
		end
	end

	function automatic dogc_pkg::in_item_t pixel_req(input dogc_pkg::opcode_t op,
			input int col, input int line, input int val);
		dogc_pkg::in_item_t it;
		it.opcode = op;
		it.column = 12'(col);
		it.row    = 4'(line);
		it.value  = 17'(val);
		return it;
	endfunction

	function automatic logic [11:0] col_in_use();
		int lim;
		lim = (cur_width == 0) ? 1 : ((cur_width > 4096) ? 4096 : int'(cur_width));
		return 12'($urandom_range(0, lim - 1));
	endfunction

	function automatic logic [3:0] row_in_use();
		int lim;
		lim = (cur_lines == 0) ? 1 : ((cur_lines > 16) ? 16 : int'(cur_lines));
		return 4'($urandom_range(0, lim - 1));
	endfunction

	function automatic int gain_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return $urandom_range(2048, 8192);
		end
		if (r < 70) begin
			return int'(dogc_pkg::GAIN_ONE);
		end
		return $urandom_range(0, 131071);
	endfunction

	function automatic int table_level();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 4000);
	endfunction

	task automatic push_item(input dogc_pkg::in_item_t it);
		int gap;
		gap = idle_len(in_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	task automatic write_reg(input logic [dogc_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int eo, input int eg, input int eb, input int tgt,
			input int depth, input int width, input int lines);
		write_reg(dogc_pkg::CFG_OFFSET_EN,       {15'($urandom), 1'(eo)});
		write_reg(dogc_pkg::CFG_GAIN_EN,         {15'($urandom), 1'(eg)});
		write_reg(dogc_pkg::CFG_BASE_EN,         {15'($urandom), 1'(eb)});
		write_reg(dogc_pkg::CFG_TARGET_BASELINE, 16'(tgt));
		write_reg(dogc_pkg::CFG_OUT_DEPTH,       16'(depth));
		write_reg(dogc_pkg::CFG_LINE_WIDTH,      16'(width));
		write_reg(dogc_pkg::CFG_LINE_COUNT,      16'(lines));
		cur_width = 13'(width);
		cur_lines = 5'(lines);
		for (int i = 0; i < 4; i++) begin
			hot_col[i] = col_in_use();
			hot_row[i] = row_in_use();
		end
		in_steady  = ($urandom_range(0, 3) == 0);
		out_steady = ($urandom_range(0, 3) == 0);
		settings_used++;
	endtask

	// Calibrates one pixel and then corrects it a few times.
	task automatic calib_burst();
		int c;
		int r;
		c = int'(hot_col[$urandom_range(0, 3)]);
		r = int'(hot_row[$urandom_range(0, 3)]);
		push_item(pixel_req(dogc_pkg::OP_WR_OFFSET, c, r, table_level()));
		push_item(pixel_req(dogc_pkg::OP_WR_GAIN, c, r, gain_code()));
		push_item(pixel_req(dogc_pkg::OP_WR_BASELINE, c, r, table_level()));
		repeat ($urandom_range(1, 3)) begin
			push_item(pixel_req(dogc_pkg::OP_CORRECT, c, r, $urandom_range(0, 131071)));
		end
	endtask

	task automatic random_item();
		int                r;
		int                c;
		int                line;
		int                val;
		dogc_pkg::opcode_t op;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			c = int'(($urandom_range(0, 9) < 6) ? hot_col[$urandom_range(0, 3)] : col_in_use());
			line = int'(($urandom_range(0, 9) < 6) ? hot_row[$urandom_range(0, 3)] :
				row_in_use());
			op = dogc_pkg::opcode_t'($urandom_range(0, 4) < 2 ? 0 : $urandom_range(1, 3));
			case (op) inside
				dogc_pkg::OP_WR_GAIN: val = gain_code();
				dogc_pkg::OP_WR_OFFSET, dogc_pkg::OP_WR_BASELINE: val = table_level();
				default: val = $urandom_range(0, 131071);
			endcase
		end else begin
			op   = dogc_pkg::opcode_t'($urandom_range(0, 3));
			c    = $urandom_range(0, 4095);
			line = $urandom_range(0, 15);
			val  = $urandom_range(0, 131071);
		end
		push_item(pixel_req(op, c, line, val));
	endtask

	task automatic random_phase(input int p);
		int start;
		case (p)
			0: set_config(1, 1, 1, 0, 8, 1, 1);
			1: set_config(1, 1, 1, 65535, 16, 4096, 16);
			2: set_config(0, 1, 0, $urandom_range(0, 65535), 14, 8191, 31);
			3: set_config(1, 0, 1, $urandom_range(0, 2000), 10, $urandom_range(1, 64), 3);
			default: set_config($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
				($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 500),
				$urandom_range(8, 16),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64),
				$urandom_range(1, 16));
		endcase
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 99) < 30) begin
				calib_burst();
			end else begin
				random_item();
			end
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Table extremes, row folding, column rejection and half-up rounding.
		set_config(1, 1, 1, 1000, 12, 100, 4);
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 0, 0, 0));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 99, 3, 131071));
		push_item(pixel_req(dogc_pkg::OP_WR_OFFSET, 5, 2, 131071));
		push_item(pixel_req(dogc_pkg::OP_WR_GAIN, 5, 2, 131071));
		push_item(pixel_req(dogc_pkg::OP_WR_BASELINE, 5, 2, 65535));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 5, 2, 131071));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 5, 2, 0));
		push_item(pixel_req(dogc_pkg::OP_WR_GAIN, 7, 9, 2048));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 7, 0, 1));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 7, 15, 3));
		push_item(pixel_req(dogc_pkg::OP_WR_GAIN, 8, 1, 0));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 8, 1, 77777));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 100, 0, 500));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 4095, 3, 500));
		push_item(pixel_req(dogc_pkg::OP_WR_OFFSET, 100, 0, 300));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 99, 0, 12345));
		push_item(pixel_req(dogc_pkg::OP_WR_BASELINE, 9, 3, 65535));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 9, 3, 500));
		drain();

		set_config(0, 0, 0, 65535, 16, 4096, 16);
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 5, 2, 131071));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 4095, 15, 0));
		drain();

		// Out-of-range bit depths and the unused index must leave the settings alone.
		write_reg(dogc_pkg::CFG_OUT_DEPTH, 16'd20);
		write_reg(dogc_pkg::CFG_OUT_DEPTH, 16'd3);
		write_reg(CFG_UNUSED, 16'hFFFF);
		write_reg(dogc_pkg::CFG_TARGET_BASELINE, 16'd0);
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 0, 0, 70000));
		drain();

		// With no columns in use every item is rejected; with no lines every row folds.
		set_config(1, 1, 0, 0, 14, 0, 1);
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 0, 0, 1234));
		push_item(pixel_req(dogc_pkg::OP_WR_GAIN, 0, 0, 0));
		drain();
		set_config(1, 1, 0, 0, 14, 4096, 0);
		push_item(pixel_req(dogc_pkg::OP_WR_OFFSET, 1, 7, 100));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 1, 0, 50));
		push_item(pixel_req(dogc_pkg::OP_CORRECT, 1, 11, 150));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_phase(p);
		end

		repeat (LATENCY * 4) @(posedge clk);
		$display("Run covered %0d pixel and table transfers under %0d register settings.",
			items_sent, settings_used);
		$display("%0d output transfers were compared with the predicted corrections.",
			results_checked);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- detector_offset_gain_correction_unit.f -----
rtl/dogc_pkg.sv
rtl/dogc_cfg_regs.sv
rtl/dogc_tables.sv
rtl/dogc_arith.sv
rtl/detector_offset_gain_correction_unit.sv
verif/dogc_checker.sv
verif/tb.sv
